FILE: src/sorted_spiral_matrix_fill_defines.svh
// Assertion macros shared by the checker files.
`ifndef SORTED_SPIRAL_MATRIX_FILL_DEFINES_SVH
`define SORTED_SPIRAL_MATRIX_FILL_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SSMF_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define SSMF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

FILE: src/ssmf_pkg.sv
// ---------------------------------------------------------------------------
// ssmf_pkg
// Shared constants, types and the spiral position function.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package ssmf_pkg;
  localparam int MaxSide  = 8;
  localparam int Depth    = MaxSide * MaxSide;
  localparam int IdxW     = $clog2(Depth);
  localparam int CntW     = IdxW + 1;
  localparam int CoordW   = $clog2(MaxSide);
  localparam int SideW    = 4;
  localparam int DataW    = 32;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [CntW-1:0]   cnt_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic clear;     // start a new matrix
    logic load;      // sorter takes one value
    logic copy;      // shift slot 0 into the RAM at wr_idx
    idx_t wr_idx;
    coord_t row;
    coord_t col;
  } ssmf_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    cnt_t count;     // values currently held
  } ssmf_sts_t;

  // Spiral index of cell (r, c) in an n by n matrix: ring k = min distance
  // to an edge; offset within the ring follows top, right, bottom, left.
  function automatic idx_t spiral_idx(input coord_t r, input coord_t c,
                                      input logic [SideW-1:0] n);
    int k, m, base, off, ri, ci, ni;
    begin
      ri = int'(r); ci = int'(c); ni = int'(n);
      k = ri;
      if (ci < k) k = ci;
      if (ni - 1 - ri < k) k = ni - 1 - ri;
      if (ni - 1 - ci < k) k = ni - 1 - ci;
      base = ni * ni - (ni - 2 * k) * (ni - 2 * k);
      m = ni - 2 * k - 1;
      if (m == 0) off = 0;
      else if (ri == k) off = ci - k;
      else if (ci == ni - 1 - k) off = m + (ri - k);
      else if (ri == ni - 1 - k) off = 2 * m + (ni - 1 - k - ci);
      else off = 3 * m + (ni - 1 - k - ri);
      spiral_idx = idx_t'(base + off);
    end
  endfunction
endpackage

FILE: src/ssmf_ram.sv
// ---------------------------------------------------------------------------
// ssmf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ssmf_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: src/ssmf_datapath.sv
// ---------------------------------------------------------------------------
// ssmf_datapath
// Shift-register insertion sorter, copy into RAM, spiral read-out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ssmf_datapath import ssmf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ssmf_cmd_t               cmd_i,
  input  logic [SideW-1:0]        side_i,
  input  logic signed [DataW-1:0] value_i,
  output ssmf_sts_t               sts_o,
  output logic signed [DataW-1:0] rdata_o
);
  // Sorted slots, each compares against the new value at a fixed place.
  logic signed [DataW-1:0] slot_q [Depth];
  logic signed [DataW-1:0] slot_d [Depth];
  cnt_t count_q;
  idx_t rd_addr;

  // Insertion while loading, shift toward slot 0 while copying.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      logic in_lt, prev_lt;
      in_lt = (cnt_t'(i) < count_q) && (value_i < slot_q[i]);
      prev_lt = (i > 0) ? ((cnt_t'(i - 1) < count_q) &&
                           (value_i < slot_q[(i > 0) ? i - 1 : 0])) : 1'b0;
      slot_d[i] = slot_q[i];
      if (cmd_i.copy) begin
        slot_d[i] = slot_q[(i < Depth - 1) ? i + 1 : i];
      end else if (cnt_t'(i) == count_q || in_lt) begin
        slot_d[i] = prev_lt ? slot_q[(i > 0) ? i - 1 : 0] : value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.copy) slot_q <= slot_d;
  end

  // Count of values held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= count_q + cnt_t'(1);
    end
  end

  // Sorted values land in the RAM in ascending order; read at the spiral index.
  assign rd_addr = spiral_idx(cmd_i.row, cmd_i.col, side_i);

  ssmf_ram #(.Width(DataW), .Depth(Depth)) u_ram (
    .clk_i(clk_i), .we_i(cmd_i.copy), .waddr_i(cmd_i.wr_idx), .wdata_i(slot_q[0]),
    .raddr_i(rd_addr), .rdata_o(rdata_o)
  );

  assign sts_o.count = count_q;
endmodule

FILE: src/ssmf_ctrl.sv
// ---------------------------------------------------------------------------
// ssmf_ctrl
// Load / copy / emit sequencer and output register control.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ssmf_ctrl import ssmf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SideW-1:0] side_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  ssmf_sts_t        sts_i,
  output ssmf_cmd_t        cmd_o,
  output coord_t           row_o,
  output coord_t           col_o,
  output logic             last_o
);
  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StCopy = 2'd1;
  localparam logic [1:0] StRead = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] state_q, state_d;
  coord_t r_q, r_d, c_q, c_d;
  idx_t copy_q, copy_d;
  coord_t nm1;
  cnt_t total;
  logic cfg_wr, in_acc, out_acc, cell_last;

  assign nm1 = coord_t'(side_i - 4'd1);
  assign total = cnt_t'(side_i) * cnt_t'(side_i);
  assign cfg_ready_o = (state_q == StLoad);
  assign cfg_wr = cfg_valid_i && cfg_ready_o;
  // a side write takes the cycle, so input waits
  assign in_stall = (state_q != StLoad) || cfg_valid_i;
  assign in_acc = in_valid && !in_stall;
  assign out_valid = (state_q == StOut);
  assign out_acc = out_valid && !out_stall;
  assign cell_last = (r_q == nm1) && (c_q == nm1);

  always_comb begin
    state_d = state_q;
    r_d = r_q;
    c_d = c_q;
    copy_d = copy_q;
    cmd_o = '0;
    cmd_o.row = r_q;
    cmd_o.col = c_q;
    cmd_o.wr_idx = copy_q;
    case (state_q)
      StLoad: begin
        if (cfg_wr) begin
          cmd_o.clear = 1'b1;
        end else if (in_acc) begin
          cmd_o.load = 1'b1;
          if (sts_i.count + cnt_t'(1) == total) begin
            state_d = StCopy;
            copy_d = '0;
          end
        end
      end
      StCopy: begin
        cmd_o.copy = 1'b1;
        if (cnt_t'(copy_q) + cnt_t'(1) == total) begin
          state_d = StRead;
          r_d = '0;
          c_d = '0;
        end else begin
          copy_d = copy_q + idx_t'(1);
        end
      end
      StRead: begin
        state_d = StOut;
      end
      StOut: begin
        if (out_acc) begin
          if (cell_last) begin
            cmd_o.clear = 1'b1;
            state_d = StLoad;
          end else begin
            state_d = StRead;
            if (c_q == nm1) begin
              c_d = '0;
              r_d = r_q + coord_t'(1);
            end else begin
              c_d = c_q + coord_t'(1);
            end
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      r_q <= '0;
      c_q <= '0;
      copy_q <= '0;
    end else begin
      state_q <= state_d;
      r_q <= r_d;
      c_q <= c_d;
      copy_q <= copy_d;
    end
  end

  assign row_o = r_q;
  assign col_o = c_q;
  assign last_o = cell_last;
endmodule

FILE: src/sorted_spiral_matrix_fill.sv
// Sorted spiral matrix fill.
// Input channel (in_valid / in_stall, value_i): one signed value per transfer,
// one per cycle while loading and cfg_valid is low; values are kept sorted
// by a parallel-compare shift sorter. After side*side values the block stops
// taking input, shifts the sorted values into the RAM and then emits the
// matrix in row-major order on the output channel (out_valid / out_stall,
// value_res_o, row_o, col_o, last_o), last_o high on the final cell.
// After the final input transfer the copy state runs, then a spiral RAM read
// state, and then the first result is presented. Each result takes a spiral
// RAM read state, then a present state; input opens again the cycle after
// the last result transfer.
// A stall on the output holds the current result; no input is taken during
// copy or emission. Config channel (cfg_valid / cfg_ready, side_i): ready
// only while loading, and input is stalled while cfg_valid is high; side 0
// acts as 1 and above 8 as 8; a write drops any partial load.
// Reset: side 8, empty matrix, no result pending.
// ---------------------------------------------------------------------------
// sorted_spiral_matrix_fill
// Top level: config register, controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sorted_spiral_matrix_fill import ssmf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SideW-1:0]        side_i,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DataW-1:0] value_res_o,
  output logic [CoordW-1:0]       row_o,
  output logic [CoordW-1:0]       col_o,
  output logic                    last_o
);
  logic [SideW-1:0] side_q, eff_side;
  logic cfg_wr;
  ssmf_cmd_t cmd;
  ssmf_sts_t sts;

  assign cfg_wr = cfg_valid && cfg_ready;

  // Side register, reset to the full size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideW'(MaxSide);
    end else if (cfg_wr) begin
      side_q <= side_i;
    end
  end

  // Clamp to 1..MaxSide.
  always_comb begin
    if (side_q == '0) eff_side = SideW'(1);
    else if (side_q > SideW'(MaxSide)) eff_side = SideW'(MaxSide);
    else eff_side = side_q;
  end

  ssmf_ctrl u_ctrl (
    .clk_i, .rst_ni, .side_i(eff_side), .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .in_valid, .in_stall, .out_valid, .out_stall,
    .sts_i(sts), .cmd_o(cmd), .row_o, .col_o, .last_o
  );

  ssmf_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .side_i(eff_side), .value_i,
    .sts_o(sts), .rdata_o(value_res_o)
  );
endmodule

FILE: src/ssmf_checker.sv
// ---------------------------------------------------------------------------
// ssmf_checker
// Port-level checks of the sorted spiral matrix fill.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_spiral_matrix_fill_defines.svh"
module ssmf_port_checker import ssmf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CoordW-1:0] row_o,
  input logic [CoordW-1:0] col_o,
  input logic              last_o
);
  `SSMF_ASSERT_IMP(a_no_in_while_out, clk_i, rst_ni, out_valid, in_stall,
    "input open during emission")
  `SSMF_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && out_stall,
    out_valid && $stable(row_o) && $stable(col_o), "stalled result changed")
  `SSMF_ASSERT_NEXT(a_last_done, clk_i, rst_ni, out_valid && !out_stall && last_o,
    !out_valid, "emission continued after last")
  // first result of a matrix follows the copy, not a single read gap
  `SSMF_ASSERT_IMP(a_first_cell, clk_i, rst_ni, $rose(out_valid) && $past(!out_valid, 2),
    row_o == '0 && col_o == '0, "emission not at origin")
endmodule

bind sorted_spiral_matrix_fill ssmf_port_checker u_checker (
  .clk_i, .rst_ni, .in_stall, .out_valid, .out_stall, .row_o, .col_o, .last_o
);
